// File: rtl/luc_pkg.sv
// Shared types, constants and the sRGB-to-linear table for the
// linearize/unique-colors block. No dependencies.
package luc_pkg;

    localparam int ChanW    = 8;
    localparam int AddrW    = 2 * ChanW;
    localparam int RowMarks = 1 << ChanW;
    localparam int TagW     = 16;

    typedef logic [ChanW-1:0]    t_chan;
    typedef logic [AddrW-1:0]    t_row_addr;
    typedef logic [TagW-1:0]     t_tag;
    typedef logic [RowMarks-1:0] t_marks;

    localparam t_tag TagFirst = t_tag'(1);
    localparam t_tag TagLast  = '1;

    typedef struct packed {
        t_tag   tag;
        t_marks marks;
    } t_row;

    typedef struct packed {
        logic      we;
        t_row_addr waddr;
        t_row      wdata;
        t_row_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic  valid;
        t_chan blue;
        t_chan green;
        t_chan red;
    } t_emit;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } t_state;

    localparam t_chan LinTable [0:255] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd8,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
        8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
        8'd17,  8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,
        8'd20,  8'd21,  8'd22,  8'd22,  8'd23,  8'd23,  8'd24,  8'd24,
        8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,
        8'd30,  8'd30,  8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,
        8'd35,  8'd36,  8'd37,  8'd37,  8'd38,  8'd39,  8'd40,  8'd41,
        8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd45,  8'd46,  8'd47,
        8'd48,  8'd49,  8'd50,  8'd51,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,
        8'd71,  8'd72,  8'd73,  8'd74,  8'd76,  8'd77,  8'd78,  8'd79,
        8'd80,  8'd81,  8'd82,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
        8'd90,  8'd91,  8'd92,  8'd93,  8'd95,  8'd96,  8'd97,  8'd99,
        8'd100, 8'd101, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109,
        8'd111, 8'd112, 8'd114, 8'd115, 8'd116, 8'd118, 8'd119, 8'd121,
        8'd122, 8'd124, 8'd125, 8'd127, 8'd128, 8'd130, 8'd131, 8'd133,
        8'd134, 8'd136, 8'd138, 8'd139, 8'd141, 8'd142, 8'd144, 8'd146,
        8'd147, 8'd149, 8'd151, 8'd152, 8'd154, 8'd156, 8'd157, 8'd159,
        8'd161, 8'd163, 8'd164, 8'd166, 8'd168, 8'd170, 8'd171, 8'd173,
        8'd175, 8'd177, 8'd179, 8'd181, 8'd183, 8'd184, 8'd186, 8'd188,
        8'd190, 8'd192, 8'd194, 8'd196, 8'd198, 8'd200, 8'd202, 8'd204,
        8'd206, 8'd208, 8'd210, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220,
        8'd222, 8'd224, 8'd226, 8'd229, 8'd231, 8'd233, 8'd235, 8'd237,
        8'd239, 8'd242, 8'd244, 8'd246, 8'd248, 8'd250, 8'd253, 8'd255
    };

endpackage

// File: rtl/luc_seen_ram.sv
// Seen-mark memory: one row per (red, green) pair, holding an epoch tag and
// one mark per blue value. One write port, one registered read port. Uses luc_pkg.
module luc_seen_ram (
    input  logic              i_clk,
    input  luc_pkg::t_ram_req i_req,
    output luc_pkg::t_row     o_rd
);

    luc_pkg::t_row mem [0:(1 << luc_pkg::AddrW)-1];
    luc_pkg::t_row r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= mem[i_req.raddr];
    end

    assign o_rd = r_rd;

endmodule

// File: rtl/luc_ctrl.sv
// Sequencer for the seen-mark read-modify-write, epoch tracking and the
// memory clearing pass. Uses luc_pkg; drives luc_seen_ram.
module luc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_new_image,
    input  luc_pkg::t_chan    i_blue,
    input  luc_pkg::t_chan    i_green,
    input  luc_pkg::t_chan    i_red,
    input  luc_pkg::t_row     i_rd,
    output luc_pkg::t_ram_req o_req,
    output luc_pkg::t_emit    o_emit,
    output logic              o_busy
);

    luc_pkg::t_state    r_state, n_state;
    luc_pkg::t_tag      r_epoch, n_epoch;
    luc_pkg::t_row_addr r_sweep, n_sweep;
    logic               r_pend, n_pend;
    luc_pkg::t_chan     r_blue, n_blue;
    luc_pkg::t_chan     r_green, n_green;
    luc_pkg::t_chan     r_red, n_red;

    logic               accept;
    luc_pkg::t_marks    marks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= luc_pkg::ST_CLEAR;
            r_epoch <= luc_pkg::TagFirst;
            r_sweep <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_epoch <= n_epoch;
            r_sweep <= n_sweep;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blue  <= n_blue;
        r_green <= n_green;
        r_red   <= n_red;
    end

    always_comb begin
        n_state = r_state;
        n_epoch = r_epoch;
        n_sweep = r_sweep;
        n_pend  = r_pend;
        n_blue  = r_blue;
        n_green = r_green;
        n_red   = r_red;
        accept  = 1'b0;
        marks   = (i_rd.tag == r_epoch) ? i_rd.marks : '0;
        o_busy  = (r_state != luc_pkg::ST_IDLE);
        o_req.we    = 1'b0;
        o_req.waddr = {r_red, r_green};
        o_req.wdata = '0;
        o_req.raddr = {r_red, r_green};
        o_emit.valid = 1'b0;
        o_emit.blue  = r_blue;
        o_emit.green = r_green;
        o_emit.red   = r_red;

        case (r_state)
            luc_pkg::ST_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_sweep;
                n_sweep     = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_epoch = luc_pkg::TagFirst;
                    n_pend  = 1'b0;
                    n_state = r_pend ? luc_pkg::ST_READ : luc_pkg::ST_IDLE;
                end
            end
            luc_pkg::ST_IDLE: begin
                accept      = i_start;
                o_req.raddr = {i_red, i_green};
                if (accept) begin
                    n_blue  = i_blue;
                    n_green = i_green;
                    n_red   = i_red;
                    n_state = luc_pkg::ST_CHECK;
                    if (i_new_image) begin
                        if (r_epoch == luc_pkg::TagLast) begin
                            n_state = luc_pkg::ST_CLEAR;
                            n_pend  = 1'b1;
                            n_sweep = '0;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end
                end
            end
            luc_pkg::ST_READ: begin
                n_state = luc_pkg::ST_CHECK;
            end
            luc_pkg::ST_CHECK: begin
                n_state = luc_pkg::ST_IDLE;
                if (!marks[r_blue]) begin
                    o_req.we     = 1'b1;
                    o_req.wdata  = {r_epoch, marks | (luc_pkg::t_marks'(1) << r_blue)};
                    o_emit.valid = 1'b1;
                end
            end
            default: begin
                n_state = luc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/linearize_and_unique_colors.sv
// Top level: sRGB-to-linear lookup, seen-mark sequencer and memory, result
// register. Uses luc_pkg, luc_ctrl, luc_seen_ram.
//
//  channel | handshake             | signals
//  --------+-----------------------+---------------------------------------------
//  pixel   | start & !busy         | i_new_image, i_blue_in, i_green_in, i_red_in
//  result  | o_strobe (one cycle)  | o_blue_lin, o_green_lin, o_red_lin
//
// A pixel is accepted in ST_IDLE, which issues the mark-row read; ST_CHECK then
// checks and writes back the row; busy is high in ST_CHECK.
// o_strobe and the result are registered from the ST_CHECK write-back.
// After reset, and on the new image that wraps the 16-bit epoch (every 65535th),
// a clearing pass sweeps all 65536 rows of the mark memory with busy high.
// Results are never stalled; the result register frees the core for the next pixel.
module linearize_and_unique_colors (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_new_image,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_red_in,
    output logic       o_strobe,
    output logic [7:0] o_blue_lin,
    output logic [7:0] o_green_lin,
    output logic [7:0] o_red_lin
);

    luc_pkg::t_chan    lin_blue, lin_green, lin_red;
    luc_pkg::t_ram_req ram_req;
    luc_pkg::t_row     ram_rd;
    luc_pkg::t_emit    emit;

    logic              r_strobe;
    luc_pkg::t_chan    r_blue, r_green, r_red;

    assign lin_blue  = luc_pkg::LinTable[i_blue_in];
    assign lin_green = luc_pkg::LinTable[i_green_in];
    assign lin_red   = luc_pkg::LinTable[i_red_in];

    luc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_new_image (i_new_image),
        .i_blue      (lin_blue),
        .i_green     (lin_green),
        .i_red       (lin_red),
        .i_rd        (ram_rd),
        .o_req       (ram_req),
        .o_emit      (emit),
        .o_busy      (busy)
    );

    luc_seen_ram u_ram (
        .i_clk (i_clk),
        .i_req (ram_req),
        .o_rd  (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_blue  <= emit.blue;
            r_green <= emit.green;
            r_red   <= emit.red;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_blue_lin  = r_blue;
    assign o_green_lin = r_green;
    assign o_red_lin   = r_red;

endmodule

// File: rtl/luc_checker.sv
// Port-level checks for linearize_and_unique_colors, attached by bind.
// Depends only on the top level's ports.
module luc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_new_image,
    input logic [7:0] i_blue_in,
    input logic [7:0] i_green_in,
    input logic [7:0] i_red_in,
    input logic       o_strobe,
    input logic [7:0] o_blue_lin,
    input logic [7:0] o_green_lin,
    input logic [7:0] o_red_lin
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("no clearing pass after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a pixel transfer");

    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on consecutive cycles");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a pixel in work");

    a_known_transfers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((start && !busy) |-> !$isunknown({i_new_image, i_blue_in, i_green_in, i_red_in}))
        and (o_strobe |-> !$isunknown({o_blue_lin, o_green_lin, o_red_lin})))
        else $error("unknown bits in a transfer");

endmodule

bind linearize_and_unique_colors luc_checker u_luc_checker (.*);

// File: bench/luc_unique_color_checker.sv
// Checker for linearize_and_unique_colors: watches pixel and result transfers,
// predicts the linear first-seen colors and compares them. Uses luc_pkg types.
module luc_unique_color_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  logic           i_new_image,
    input  luc_pkg::t_chan i_blue_in,
    input  luc_pkg::t_chan i_green_in,
    input  luc_pkg::t_chan i_red_in,
    input  logic           i_strobe,
    input  luc_pkg::t_chan i_blue_lin,
    input  luc_pkg::t_chan i_green_lin,
    input  luc_pkg::t_chan i_red_lin,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // round(255 * lin(v / 255)), half to even
    localparam int unsigned SRGB_TO_LIN [0:255] = '{
        0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3, 3,
        4, 4, 4, 4, 4, 5, 5, 5, 5, 6, 6, 6, 6, 7, 7, 7,
        8, 8, 8, 8, 9, 9, 9, 10, 10, 10, 11, 11, 12, 12, 12, 13,
        13, 13, 14, 14, 15, 15, 16, 16, 17, 17, 17, 18, 18, 19, 19, 20,
        20, 21, 22, 22, 23, 23, 24, 24, 25, 25, 26, 27, 27, 28, 29, 29,
        30, 30, 31, 32, 32, 33, 34, 35, 35, 36, 37, 37, 38, 39, 40, 41,
        41, 42, 43, 44, 45, 45, 46, 47, 48, 49, 50, 51, 51, 52, 53, 54,
        55, 56, 57, 58, 59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 69, 70,
        71, 72, 73, 74, 76, 77, 78, 79, 80, 81, 82, 84, 85, 86, 87, 88,
        90, 91, 92, 93, 95, 96, 97, 99, 100, 101, 103, 104, 105, 107, 108, 109,
        111, 112, 114, 115, 116, 118, 119, 121, 122, 124, 125, 127, 128, 130, 131, 133,
        134, 136, 138, 139, 141, 142, 144, 146, 147, 149, 151, 152, 154, 156, 157, 159,
        161, 163, 164, 166, 168, 170, 171, 173, 175, 177, 179, 181, 183, 184, 186, 188,
        190, 192, 194, 196, 198, 200, 202, 204, 206, 208, 210, 212, 214, 216, 218, 220,
        222, 224, 226, 229, 231, 233, 235, 237, 239, 242, 244, 246, 248, 250, 253, 255
    };

    typedef struct packed {
        luc_pkg::t_chan blue;
        luc_pkg::t_chan green;
        luc_pkg::t_chan red;
    } t_lin_pixel;

    t_lin_pixel  lin_pixels_due [$];
    bit          seen_linear [int unsigned];
    int          fail_count = 0;

    function automatic void expand_and_filter(logic ni, luc_pkg::t_chan b, luc_pkg::t_chan g,
                                              luc_pkg::t_chan r);
        t_lin_pixel  lp;
        int unsigned key;
        lp.blue  = luc_pkg::t_chan'(SRGB_TO_LIN[b]);
        lp.green = luc_pkg::t_chan'(SRGB_TO_LIN[g]);
        lp.red   = luc_pkg::t_chan'(SRGB_TO_LIN[r]);
        key = {8'd0, lp.red, lp.green, lp.blue};
        if (ni)
            seen_linear.delete();
        if (!seen_linear.exists(key)) begin
            seen_linear[key] = 1'b1;
            lin_pixels_due = {lin_pixels_due, lp};
        end
    endfunction

    function automatic void note_failure(string what, t_lin_pixel exp_px, t_lin_pixel act_px);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s exp b=%0d g=%0d r=%0d act b=%0d g=%0d r=%0d", $realtime, what,
                     exp_px.blue, exp_px.green, exp_px.red,
                     act_px.blue, act_px.green, act_px.red);
    endfunction

    always @(posedge i_clk) begin
        t_lin_pixel act_px;
        t_lin_pixel exp_px;
        if (i_rst_n) begin
            if (i_strobe) begin
                act_px = '{i_blue_lin, i_green_lin, i_red_lin};
                if (lin_pixels_due.size() == 0) begin
                    note_failure("unexpected result", '0, act_px);
                end else begin
                    exp_px = lin_pixels_due.pop_front();
                    if (act_px != exp_px)
                        note_failure("result mismatch", exp_px, act_px);
                end
            end
            if (i_start && !i_busy)
                expand_and_filter(i_new_image, i_blue_in, i_green_in, i_red_in);
        end
        o_fail_count <= fail_count;
        o_pending    <= lin_pixels_due.size();
    end

endmodule

// File: bench/tb_linearize_and_unique_colors.sv
// Testbench top for linearize_and_unique_colors: drives pixel transfers,
// runs a watchdog and gives the verdict. Uses luc_pkg and luc_unique_color_checker.
module tb_linearize_and_unique_colors;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;
    localparam int RANDOM_PIXELS = 400;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    logic           new_image;
    luc_pkg::t_chan blue_in, green_in, red_in;
    logic           strobe;
    luc_pkg::t_chan blue_lin, green_lin, red_lin;
    int             fail_count;
    int             pending;
    int             stall_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    linearize_and_unique_colors u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_new_image (new_image),
        .i_blue_in   (blue_in),
        .i_green_in  (green_in),
        .i_red_in    (red_in),
        .o_strobe    (strobe),
        .o_blue_lin  (blue_lin),
        .o_green_lin (green_lin),
        .o_red_lin   (red_lin)
    );

    luc_unique_color_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_new_image  (new_image),
        .i_blue_in    (blue_in),
        .i_green_in   (green_in),
        .i_red_in     (red_in),
        .i_strobe     (strobe),
        .i_blue_lin   (blue_lin),
        .i_green_lin  (green_lin),
        .i_red_lin    (red_lin),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // covers the clearing pass after reset
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(logic ni, luc_pkg::t_chan b, luc_pkg::t_chan g,
                              luc_pkg::t_chan r, int gap);
        if (gap > 0) begin
            @(negedge clk) start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        new_image <= ni;
        blue_in   <= b;
        green_in  <= g;
        red_in    <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk) start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial begin
        int          sent;
        int          img_len;
        int          pal_n;
        int          k;
        logic [23:0] palette [8];
        logic [23:0] px;
        bit          narrow;
        bit          no_idle;
        bit          drained;
        logic        ni;

        rst_n     = 1'b0;
        start     = 1'b0;
        new_image = 1'b0;
        blue_in   = '0;
        green_in  = '0;
        red_in    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: extremes, duplicates, linear collisions, new image on a repeat
        send_pixel(1'b1, 8'd0,   8'd0,   8'd0,   pick_gap());
        send_pixel(1'b0, 8'd0,   8'd0,   8'd0,   pick_gap());
        send_pixel(1'b0, 8'd6,   8'd6,   8'd6,   pick_gap());
        send_pixel(1'b0, 8'd7,   8'd7,   8'd7,   pick_gap());
        send_pixel(1'b0, 8'd17,  8'd16,  8'd8,   pick_gap());
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255, pick_gap());
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255, pick_gap());
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255, pick_gap());
        send_pixel(1'b0, 8'd255, 8'd0,   8'd0,   pick_gap());
        send_pixel(1'b0, 8'd0,   8'd255, 8'd0,   pick_gap());
        send_pixel(1'b0, 8'd0,   8'd0,   8'd255, pick_gap());
        send_pixel(1'b0, 8'hAA,  8'h55,  8'hAA,  0);
        send_pixel(1'b0, 8'h55,  8'hAA,  8'h55,  0);
        send_pixel(1'b0, 8'hAA,  8'h55,  8'hAA,  0);
        send_pixel(1'b0, 8'd10,  8'd10,  8'd10,  0);
        send_pixel(1'b0, 8'd8,   8'd15,  8'd17,  0);
        send_pixel(1'b0, 8'd128, 8'd64,  8'd200, pick_gap());
        send_pixel(1'b0, 8'd129, 8'd64,  8'd200, pick_gap());
        send_pixel(1'b1, 8'd0,   8'd0,   8'd0,   pick_gap());
        send_pixel(1'b0, 8'd254, 8'd1,   8'd127, pick_gap());
        send_pixel(1'b1, 8'd254, 8'd1,   8'd127, pick_gap());

        // random images built from small palettes, with stray colors and new images
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_PIXELS) begin
            img_len = $urandom_range(4, 40);
            pal_n   = $urandom_range(1, 8);
            narrow  = ($urandom_range(0, 2) == 0);
            no_idle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < 8; k++)
                palette[3'(k)] = narrow ? {8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                                           8'($urandom_range(0, 24))}
                                        : 24'($urandom);
            for (k = 0; k < img_len && sent < RANDOM_PIXELS; k++) begin
                ni = (k == 0) || ($urandom_range(0, 49) == 0);
                if ($urandom_range(0, 9) < 7)
                    px = palette[3'($urandom_range(0, pal_n - 1))];
                else
                    px = 24'($urandom);
                send_pixel(ni, px[7:0], px[15:8], px[23:16], no_idle ? 0 : pick_gap());
                sent++;
            end
            if (!drained && sent >= RANDOM_PIXELS / 2) begin
                drain_results();
                drained = 1'b1;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/luc_pkg.sv
rtl/luc_seen_ram.sv
rtl/luc_ctrl.sv
rtl/linearize_and_unique_colors.sv
rtl/luc_checker.sv
bench/luc_unique_color_checker.sv
bench/tb_linearize_and_unique_colors.sv
